### rtl/core/ugob_pkg.sv
`timescale 1ns / 1ps
package ugob_pkg;

  localparam int GRID_X       = 64;
  localparam int GRID_Z       = 64;
  localparam int POOL_ENTRIES = 4096;
  localparam int OBJECTS      = 64;

  localparam int CELLS  = GRID_X * GRID_Z;
  localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int POOL_W = $clog2(POOL_ENTRIES);
  localparam int GMAX   = (GRID_X > GRID_Z) ? GRID_X : GRID_Z;
  localparam int AX_W   = (GMAX > 1) ? $clog2(GMAX) : 1;
  localparam int N_W    = $clog2(GMAX + 1);
  localparam int OBJ_W  = 6;
  localparam int MARK_W = 16;
  localparam int CNT_W  = $clog2(OBJECTS + 1);

  localparam logic [MARK_W-1:0] STAMP_WRAP = 16'd64000;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_START  = 2'd2,
    KIND_CONT   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Z = 3'd1,
    REG_INV_CELL = 3'd2,
    REG_CELLS_X  = 3'd3,
    REG_CELLS_Z  = 3'd4
  } reg_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [OBJ_W-1:0]   object_index;
    logic signed [23:0] center_x;
    logic signed [23:0] center_z;
    logic [22:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic [OBJ_W-1:0] object_index_res;
    logic             found;
    logic [11:0]      cells_written;
    logic             overflow;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_z;
    logic [23:0]        inv_cell_width;
    logic [6:0]         cells_x;
    logic [6:0]         cells_z;
  } cfg_t;

  // classified command: cell rectangle already resolved
  typedef struct packed {
    logic [1:0]       kind;
    logic [OBJ_W-1:0] obj;
    logic [AX_W-1:0]  x0;
    logic [AX_W-1:0]  x1;
    logic [AX_W-1:0]  z0;
    logic [AX_W-1:0]  z1;
    logic [N_W-1:0]   nx;
  } cmd_t;

  function automatic logic [N_W-1:0] used_cells(logic [6:0] r, int bound);
    logic [N_W-1:0] res;
    if (r == 7'd0) begin
      res = N_W'(1);
    end else if (int'(r) > bound) begin
      res = N_W'(bound);
    end else begin
      res = N_W'(r);
    end
    return res;
  endfunction

endpackage

### rtl/core/ugob_ram.sv
`timescale 1ns / 1ps
module ugob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/ugob_front.sv
`timescale 1ns / 1ps
module ugob_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ugob_pkg::in_item_t in_item_i,
  input  ugob_pkg::cfg_t     cfg_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output ugob_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_SAT  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e            state_q, state_d;
  ugob_pkg::in_item_t item_q, item_d;
  ugob_pkg::cmd_t     cmd_q, cmd_d;
  logic [1:0]         idx_q, idx_d;
  logic [24:0]        prod_q, prod_d;
  logic               nonpos_q, nonpos_d;

  logic signed [25:0] c_s, r_s, op_s, o_s, d_s;
  logic [48:0]        prod;
  logic [24:0]        p;
  logic [ugob_pkg::N_W-1:0]  n_used;
  logic [ugob_pkg::AX_W-1:0] cell_idx;

  // endpoints: 0 x-r, 1 x+r, 2 z-r, 3 z+r (r = 0 for queries)
  always_comb begin
    c_s  = idx_q[1] ? {{2{item_q.center_z[23]}}, item_q.center_z}
                    : {{2{item_q.center_x[23]}}, item_q.center_x};
    r_s  = (item_q.kind == ugob_pkg::KIND_INSERT) ? {3'b000, item_q.radius} : 26'sd0;
    op_s = idx_q[0] ? (c_s + r_s) : (c_s - r_s);
    o_s  = idx_q[1] ? {{2{cfg_i.origin_z[23]}}, cfg_i.origin_z}
                    : {{2{cfg_i.origin_x[23]}}, cfg_i.origin_x};
    d_s  = op_s - o_s;
    prod = 49'(d_s[24:0]) * 49'(cfg_i.inv_cell_width);
    n_used = idx_q[1] ? ugob_pkg::used_cells(cfg_i.cells_z, ugob_pkg::GRID_Z)
                      : ugob_pkg::used_cells(cfg_i.cells_x, ugob_pkg::GRID_X);
    p = nonpos_q ? 25'd0 : prod_q;
    if (p >= 25'(n_used)) begin
      cell_idx = ugob_pkg::AX_W'(n_used - ugob_pkg::N_W'(1));
    end else begin
      cell_idx = ugob_pkg::AX_W'(p);
    end
  end

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    cmd_d    = cmd_q;
    idx_d    = idx_q;
    prod_d   = prod_q;
    nonpos_d = nonpos_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          idx_d   = 2'd0;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        prod_d   = prod[48:24];
        nonpos_d = d_s[25] | (d_s == 26'sd0);
        state_d  = F_SAT;
      end
      F_SAT: begin
        case (idx_q)
          2'd0:    cmd_d.x0 = cell_idx;
          2'd1:    cmd_d.x1 = cell_idx;
          2'd2:    cmd_d.z0 = cell_idx;
          default: cmd_d.z1 = cell_idx;
        endcase
        if (idx_q == 2'd3) begin
          cmd_d.kind = item_q.kind;
          cmd_d.obj  = item_q.object_index;
          cmd_d.nx   = ugob_pkg::used_cells(cfg_i.cells_x, ugob_pkg::GRID_X);
          state_d    = F_PUSH;
        end else begin
          idx_d   = idx_q + 2'd1;
          state_d = F_MUL;
        end
      end
      F_PUSH: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    cmd_q    <= cmd_d;
    idx_q    <= idx_d;
    prod_q   <= prod_d;
    nonpos_q <= nonpos_d;
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = cmd_q;

endmodule

### rtl/core/ugob_cmd_queue.sv
`timescale 1ns / 1ps
module ugob_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  ugob_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output ugob_pkg::cmd_t pop_data_o
);

  ugob_pkg::cmd_t slot_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/ugob_back.sv
`timescale 1ns / 1ps
module ugob_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  ugob_pkg::cmd_t      cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ugob_pkg::out_item_t out_item_o,
  output logic                init_busy_o
);

  localparam int CELL_W = ugob_pkg::CELL_W;
  localparam int POOL_W = ugob_pkg::POOL_W;
  localparam int AX_W   = ugob_pkg::AX_W;
  localparam int OBJ_W  = ugob_pkg::OBJ_W;
  localparam int MARK_W = ugob_pkg::MARK_W;
  localparam int OBJ_AW = $clog2(ugob_pkg::OBJECTS);
  localparam int CNT_W  = ugob_pkg::CNT_W;

  typedef enum logic [8:0] {
    B_CLR   = 9'b000000001,
    B_IDLE  = 9'b000000010,
    B_INS   = 9'b000000100,
    B_INS_W = 9'b000001000,
    B_QH    = 9'b000010000,
    B_QHW   = 9'b000100000,
    B_QP    = 9'b001000000,
    B_QM    = 9'b010000000,
    B_DONE  = 9'b100000000
  } bstate_e;

  bstate_e             state_q, state_d;
  ugob_pkg::cmd_t      cmd_q, cmd_d;
  logic [CELL_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic                clr_res_q, clr_res_d;
  logic [POOL_W-1:0]   cursor_q, cursor_d;
  logic                full_q, full_d;
  logic [MARK_W-1:0]   stamp_q, stamp_d;
  logic [ugob_pkg::OBJECTS-1:0] mvalid_q, mvalid_d;
  logic [AX_W-1:0]     x_q, x_d, z_q, z_d;
  logic [CELL_W-1:0]   cell_q, cell_d;
  logic [11:0]         written_q, written_d;
  logic [OBJ_W-1:0]    o_q, o_d;
  logic [POOL_W-1:0]   next_q, next_d;
  logic                pend_q, pend_d;
  logic [OBJ_W-1:0]    pend_obj_q, pend_obj_d;
  logic [CNT_W-1:0]    nfound_q, nfound_d;
  logic                out_valid_q, out_valid_d;
  ugob_pkg::out_item_t out_q, out_d;

  logic                    head_we;
  logic [CELL_W-1:0]       head_waddr, head_raddr;
  logic [POOL_W-1:0]       head_wdata, head_rdata;
  logic                    pool_we;
  logic [POOL_W-1:0]       pool_waddr, pool_raddr;
  logic [OBJ_W+POOL_W-1:0] pool_wdata, pool_rdata;
  logic                    mark_we;
  logic [OBJ_AW-1:0]       mark_waddr, mark_raddr;
  logic [MARK_W-1:0]       mark_wdata, mark_rdata;

  logic [CELL_W-1:0] cell_addr;
  logic              can_emit;
  logic [MARK_W-1:0] mark_val, stamp_inc;
  logic              hit, last_cell;
  logic [POOL_W-1:0] new_entry;

  ugob_ram #(.WIDTH(POOL_W), .DEPTH(ugob_pkg::CELLS)) u_heads (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );

  ugob_ram #(.WIDTH(OBJ_W + POOL_W), .DEPTH(ugob_pkg::POOL_ENTRIES)) u_pool (
    .clk_i, .we_i(pool_we), .waddr_i(pool_waddr), .wdata_i(pool_wdata),
    .raddr_i(pool_raddr), .rdata_o(pool_rdata)
  );

  ugob_ram #(.WIDTH(MARK_W), .DEPTH(ugob_pkg::OBJECTS)) u_marks (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(mark_raddr), .rdata_o(mark_rdata)
  );

  always_comb begin
    cell_addr = CELL_W'(CELL_W'(z_q) * CELL_W'(cmd_q.nx)) + CELL_W'(x_q);
    can_emit  = !out_valid_q || out_ready_i;
    mark_val  = mvalid_q[OBJ_AW'(o_q)] ? mark_rdata : '0;
    hit       = (int'(o_q) < ugob_pkg::OBJECTS) && (mark_val != stamp_q)
                && (int'(nfound_q) < ugob_pkg::OBJECTS);
    last_cell = (x_q == cmd_q.x1) && (z_q == cmd_q.z1);
    new_entry = cursor_q + POOL_W'(1);
    stamp_inc = stamp_q + MARK_W'(1);
    if (stamp_inc > ugob_pkg::STAMP_WRAP) begin
      stamp_inc = MARK_W'(1);
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    clr_cnt_d  = clr_cnt_q;
    clr_res_d  = clr_res_q;
    cursor_d   = cursor_q;
    full_d     = full_q;
    stamp_d    = stamp_q;
    mvalid_d   = mvalid_q;
    x_d        = x_q;
    z_d        = z_q;
    cell_d     = cell_q;
    written_d  = written_q;
    o_d        = o_q;
    next_d     = next_q;
    pend_d     = pend_q;
    pend_obj_d = pend_obj_q;
    nfound_d   = nfound_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_ready_o = 1'b0;
    head_we    = 1'b0;
    head_waddr = cell_q;
    head_wdata = new_entry;
    head_raddr = cell_addr;
    pool_we    = 1'b0;
    pool_waddr = new_entry;
    pool_wdata = {cmd_q.obj, head_rdata};
    pool_raddr = next_q;
    mark_we    = 1'b0;
    mark_waddr = OBJ_AW'(o_q);
    mark_wdata = stamp_q;
    mark_raddr = OBJ_AW'(pool_rdata[OBJ_W+POOL_W-1:POOL_W]);

    unique case (state_q)
      B_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_cnt_q;
        head_wdata = '0;
        clr_cnt_d  = clr_cnt_q + CELL_W'(1);
        if (int'(clr_cnt_q) == ugob_pkg::CELLS - 1) begin
          cursor_d = '0;
          full_d   = 1'b0;
          state_d  = clr_res_q ? B_DONE : B_IDLE;
        end
      end
      B_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d     = cmd_i;
          x_d       = cmd_i.x0;
          z_d       = cmd_i.z0;
          written_d = '0;
          pend_d    = 1'b0;
          nfound_d  = '0;
          case (cmd_i.kind)
            ugob_pkg::KIND_CLEAR: begin
              clr_cnt_d = '0;
              clr_res_d = 1'b1;
              state_d   = B_CLR;
            end
            ugob_pkg::KIND_INSERT: begin
              if (int'(cmd_i.obj) < ugob_pkg::OBJECTS) begin
                mvalid_d[OBJ_AW'(cmd_i.obj)] = 1'b0;
                state_d = B_INS;
              end else begin
                state_d = B_DONE;
              end
            end
            ugob_pkg::KIND_START: begin
              stamp_d = stamp_inc;
              state_d = B_QH;
            end
            default: state_d = B_QH;
          endcase
        end
      end
      B_INS: begin
        if (full_q) begin
          state_d = B_DONE;
        end else if (int'(cursor_q) >= ugob_pkg::POOL_ENTRIES - 1) begin
          full_d  = 1'b1;
          state_d = B_DONE;
        end else begin
          cell_d  = cell_addr;
          state_d = B_INS_W;
        end
      end
      B_INS_W: begin
        // push onto the front of the cell list
        pool_we   = 1'b1;
        head_we   = 1'b1;
        cursor_d  = new_entry;
        written_d = written_q + 12'd1;
        if (last_cell) begin
          state_d = B_DONE;
        end else begin
          state_d = B_INS;
          if (x_q == cmd_q.x1) begin
            x_d = cmd_q.x0;
            z_d = z_q + AX_W'(1);
          end else begin
            x_d = x_q + AX_W'(1);
          end
        end
      end
      B_QH: begin
        state_d = B_QHW;
      end
      B_QHW: begin
        pool_raddr = head_rdata;
        state_d    = (head_rdata == '0) ? B_DONE : B_QP;
      end
      B_QP: begin
        o_d     = pool_rdata[OBJ_W+POOL_W-1:POOL_W];
        next_d  = pool_rdata[POOL_W-1:0];
        state_d = B_QM;
      end
      B_QM: begin
        // keep the mark of this entry on the read port while stalled
        mark_raddr = OBJ_AW'(o_q);
        // a new hit releases the held one, which is then known not last
        if (!(hit && pend_q && !can_emit)) begin
          if (hit) begin
            mark_we = 1'b1;
            mvalid_d[OBJ_AW'(o_q)] = 1'b1;
            if (pend_q) begin
              out_valid_d = 1'b1;
              out_d = '{object_index_res: pend_obj_q, found: 1'b1,
                        cells_written: 12'd0, overflow: 1'b0, last: 1'b0};
            end
            pend_d     = 1'b1;
            pend_obj_d = o_q;
            nfound_d   = nfound_q + CNT_W'(1);
          end
          state_d = (next_q == '0) ? B_DONE : B_QP;
        end
      end
      B_DONE: begin
        if (can_emit) begin
          out_valid_d = 1'b1;
          out_d = '{object_index_res: '0, found: 1'b0, cells_written: 12'd0,
                    overflow: 1'b0, last: 1'b1};
          if (cmd_q.kind == ugob_pkg::KIND_INSERT) begin
            out_d.cells_written = written_q;
            out_d.overflow      = full_q;
          end else if (cmd_q.kind != ugob_pkg::KIND_CLEAR && pend_q) begin
            out_d.object_index_res = pend_obj_q;
            out_d.found            = 1'b1;
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_cnt_q   <= '0;
      clr_res_q   <= 1'b0;
      cursor_q    <= '0;
      full_q      <= 1'b0;
      stamp_q     <= '0;
      mvalid_q    <= '0;
      pend_q      <= 1'b0;
      nfound_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_res_q   <= clr_res_d;
      cursor_q    <= cursor_d;
      full_q      <= full_d;
      stamp_q     <= stamp_d;
      mvalid_q    <= mvalid_d;
      pend_q      <= pend_d;
      nfound_q    <= nfound_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    x_q        <= x_d;
    z_q        <= z_d;
    cell_q     <= cell_d;
    written_q  <= written_d;
    o_q        <= o_d;
    next_q     <= next_d;
    pend_obj_q <= pend_obj_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign init_busy_o = (state_q == B_CLR) && !clr_res_q;

endmodule

### rtl/core/uniform_grid_object_binning_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake              Payload
// in       in   in_valid_i/in_ready_o  in_item_i   (ugob_pkg::in_item_t)
// out      out  out_valid_o/out_ready_i out_item_o (ugob_pkg::out_item_t)
// cfg      in   cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// Front: four cell endpoints through one 25x24 multiplier, each in a multiply
// and a saturate state, plus accept and push. Back: clear writes one head row
// per cycle; insert takes an address and a write state per covered cell;
// query reads the cell head, then each list entry in a pool and a mark state.
// After reset a clearing pass sweeps all 4096 head rows; in_ready_o stays low
// while it runs. A two-entry queue parts front and back, and the result
// register lets the back run on while a finished item waits.
module uniform_grid_object_binning_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ugob_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ugob_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [23:0]         cfg_wdata_i
);

  ugob_pkg::cfg_t cfg_q;
  ugob_pkg::cmd_t front_cmd, back_cmd;
  logic           front_valid, front_ready, q_valid, q_ready;
  logic           init_busy, fe_ready;

  // configuration registers; user writes only while block idle; not enforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x       <= '0;
      cfg_q.origin_z       <= '0;
      cfg_q.inv_cell_width <= 24'd65536;
      cfg_q.cells_x        <= 7'd64;
      cfg_q.cells_z        <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ugob_pkg::REG_ORIGIN_X: cfg_q.origin_x       <= cfg_wdata_i;
        ugob_pkg::REG_ORIGIN_Z: cfg_q.origin_z       <= cfg_wdata_i;
        ugob_pkg::REG_INV_CELL: cfg_q.inv_cell_width <= cfg_wdata_i;
        ugob_pkg::REG_CELLS_X:  cfg_q.cells_x        <= cfg_wdata_i[6:0];
        ugob_pkg::REG_CELLS_Z:  cfg_q.cells_z        <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = fe_ready & ~init_busy;

  ugob_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i & ~init_busy),
    .in_ready_o (fe_ready),
    .in_item_i,
    .cfg_i      (cfg_q),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(front_ready),
    .cmd_o      (front_cmd)
  );

  ugob_cmd_queue u_queue (
    .clk_i, .rst_ni,
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_cmd),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (back_cmd)
  );

  ugob_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(q_valid),
    .cmd_ready_o(q_ready),
    .cmd_i      (back_cmd),
    .out_valid_o,
    .out_ready_i,
    .out_item_o,
    .init_busy_o(init_busy)
  );

endmodule

### rtl/core/ugob_checker.sv
`timescale 1ns / 1ps
module ugob_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ugob_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ugob_pkg::out_item_t out_item_o,
  input logic                cfg_we_i,
  input logic [2:0]          cfg_idx_i,
  input logic [23:0]         cfg_wdata_i
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // head table sweep blocks input right after reset
  a_init_block: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_no_obj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.object_index_res == '0)
    else $error("object index without found");

  a_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.cells_written != '0 || out_item_o.overflow)
      |-> out_item_o.last && !out_item_o.found)
    else $error("insert result mixed with query result");

endmodule

bind uniform_grid_object_binning_core ugob_checker u_ugob_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i, .out_valid_o,
  .out_ready_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
);
